// ----- rtl/fpmt_pkg.sv -----
// Shared types, constants and helpers for the Fenwick prefix-maximum tree unit.
// No dependencies; every other file of the unit except fpmt_ram imports this package.
`default_nettype none

package fpmt_pkg;

    localparam int IDX_W   = 11;  // signed entry position
    localparam int VAL_W   = 31;  // node and value width
    localparam int CFG_W   = 11;  // used_size register width
    localparam int KW      = 12;  // node number, holds k + lowbit(k) for k up to 2047
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    // Word index of the configuration register (paddr[2]).
    localparam logic REG_USED_SIZE = 1'b0;

    localparam logic [CFG_W-1:0] USED_SIZE_RESET = 11'd1024;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK
    } fpmt_state_t;

    typedef struct packed {
        logic              start;
        logic              opcode;
        logic [IDX_W-1:0]  index;
        logic [VAL_W-1:0]  value;
    } fpmt_req_t;

    typedef struct packed {
        logic              done;
        logic [VAL_W-1:0]  prefix_max;
        logic              rejected;
    } fpmt_rsp_t;

    function automatic logic [KW-1:0] low_bit(input logic [KW-1:0] k);
        return k & (~k + KW'(1));
    endfunction

endpackage

`default_nettype wire

// ----- rtl/fenwick_prefix_max_tree_unit.sv -----
// Top level of the Fenwick prefix-maximum tree unit: configuration port and assembly.
// Depends on fpmt_pkg, fpmt_ram and fpmt_ctrl.
`default_nettype none

// Usage
// A request is taken at a rising edge where start is high and busy is low. opcode
// selects an update (raise the entry at index to at least value) or a prefix-maximum
// query over entries 0..index. Every request gives exactly one result: done is high
// for one cycle with prefix_max and rejected valid. There is no back-pressure on the
// result side; the receiver must take it in that cycle.
// A rejected update or an empty query answers in the cycle after acceptance.
// Any other request walks the tree, one node per cycle, through the single node RAM,
// whose registered read of the next node overlaps, for an update, the write-back of
// the previous node when the value raises it. The path has at most log2(used_size)+1
// nodes, 11 for 1024 entries. The result is registered after the last node; busy drops
// together with done, so the next request can be taken in the cycle the result is shown.
// Reset: used_size returns to 1024 and the unit runs a clearing pass that writes
// zero into every node, with busy high throughout; configuration writes are taken
// meanwhile. used_size (at byte address 0, APB, no wait states) must only be written
// while no request is in flight. Out-of-range updates set rejected; query indexes past
// the size in use are clamped to the last position.
module fenwick_prefix_max_tree_unit #(
    parameter int SIZE = 1024
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic                          opcode,
    input  wire logic [fpmt_pkg::IDX_W-1:0]    index,
    input  wire logic [fpmt_pkg::VAL_W-1:0]    value,
    output logic                               done,
    output logic      [fpmt_pkg::VAL_W-1:0]    prefix_max,
    output logic                               rejected,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [fpmt_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [fpmt_pkg::PDATA_W-1:0]  pwdata,
    output logic      [fpmt_pkg::PDATA_W-1:0]  prdata,
    output logic                               pready
);

    import fpmt_pkg::*;

    localparam int AW = $clog2(SIZE);
    // Largest size the 11-bit register can select within this tree.
    localparam int N_CAP = (SIZE < 2047) ? SIZE : 2047;

    logic [CFG_W-1:0] used_size_reg, used_size_next;
    logic             cfg_write;
    logic [KW-1:0]    n_act;
    fpmt_req_t        req;
    fpmt_rsp_t        rsp;
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [VAL_W-1:0] ram_wdata;
    logic             ram_re;
    logic [AW-1:0]    ram_raddr;
    logic [VAL_W-1:0] ram_rdata;

    // Configuration port: single register, no wait states.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_USED_SIZE);
    assign used_size_next = cfg_write ? pwdata[CFG_W-1:0] : used_size_reg;
    assign prdata    = (paddr[2] == REG_USED_SIZE)
                       ? {{(PDATA_W - CFG_W){1'b0}}, used_size_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_size_reg <= USED_SIZE_RESET;
        end
        else
        begin
            used_size_reg <= used_size_next;
        end
    end

    // A size above the tree depth behaves as the full tree.
    assign n_act = (used_size_reg > CFG_W'(N_CAP)) ? KW'(N_CAP) : KW'(used_size_reg);

    assign req.start  = start;
    assign req.opcode = opcode;
    assign req.index  = index;
    assign req.value  = value;

    fpmt_ctrl #(
        .SIZE (SIZE)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .n_act     (n_act),
        .busy      (busy),
        .rsp       (rsp),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    // Node k of the tree lives at address k-1.
    fpmt_ram #(
        .WIDTH (VAL_W),
        .DEPTH (SIZE)
    ) u_nodes (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign done       = rsp.done;
    assign prefix_max = rsp.prefix_max;
    assign rejected   = rsp.rejected;

endmodule

`default_nettype wire

// ----- rtl/fpmt_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
`default_nettype none

module fpmt_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/fpmt_ctrl.sv -----
// Request sequencer of the Fenwick prefix-maximum tree: clearing pass and node walks.
// Depends on fpmt_pkg; drives the node RAM (fpmt_ram) through its port signals.
`default_nettype none

module fpmt_ctrl #(
    parameter int SIZE = 1024
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire fpmt_pkg::fpmt_req_t       req,
    input  wire logic [fpmt_pkg::KW-1:0]   n_act,
    output logic                           busy,
    output fpmt_pkg::fpmt_rsp_t            rsp,
    output logic                           ram_we,
    output logic [$clog2(SIZE)-1:0]        ram_waddr,
    output logic [fpmt_pkg::VAL_W-1:0]     ram_wdata,
    output logic                           ram_re,
    output logic [$clog2(SIZE)-1:0]        ram_raddr,
    input  wire logic [fpmt_pkg::VAL_W-1:0] ram_rdata
);

    import fpmt_pkg::*;

    localparam int AW = $clog2(SIZE);
    localparam logic [AW-1:0] LAST_ADDR = AW'(SIZE - 1);

    fpmt_state_t      state_reg, state_next;
    logic [AW-1:0]    clr_addr_reg, clr_addr_next;
    logic [KW-1:0]    k_reg, k_next;
    logic             op_reg, op_next;
    logic [VAL_W-1:0] val_reg, val_next;
    logic [VAL_W-1:0] acc_reg, acc_next;
    fpmt_rsp_t        rsp_reg, rsp_next;

    logic             accept;
    logic [KW-1:0]    idx_u;
    logic [KW-1:0]    idx_p1;
    logic             idx_neg;
    logic             idx_high;
    logic             trivial;
    logic [KW-1:0]    k_first;
    logic [KW-1:0]    k_up;
    logic [KW-1:0]    k_down;
    logic [KW-1:0]    k_first_m1;
    logic [KW-1:0]    k_reg_m1;
    logic [KW-1:0]    k_up_m1;
    logic [KW-1:0]    k_down_m1;
    logic [VAL_W-1:0] node_max;
    logic             walk_more;

    assign accept   = req.start && (state_reg == ST_IDLE);
    assign idx_neg  = req.index[IDX_W-1];
    assign idx_u    = {1'b0, req.index};
    assign idx_p1   = idx_u + KW'(1);
    assign idx_high = (idx_u >= n_act);

    // A rejected update or an empty query needs no node access.
    assign trivial  = idx_neg || idx_high && (req.opcode == OP_UPDATE) || (n_act == '0);
    assign k_first  = (req.opcode == OP_QUERY && idx_high) ? n_act : idx_p1;

    assign k_up     = k_reg + low_bit(k_reg);
    assign k_down   = k_reg - low_bit(k_reg);
    assign k_first_m1 = k_first - KW'(1);
    assign k_reg_m1   = k_reg - KW'(1);
    assign k_up_m1    = k_up - KW'(1);
    assign k_down_m1  = k_down - KW'(1);
    assign node_max   = (ram_rdata > acc_reg) ? ram_rdata : acc_reg;
    assign walk_more  = (op_reg == OP_UPDATE) ? (k_up <= n_act) : (k_down != '0);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_addr_reg == LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept && !trivial)
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (!walk_more)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Outputs and datapath.
    always_comb
    begin
        clr_addr_next = clr_addr_reg;
        k_next        = k_reg;
        op_next       = op_reg;
        val_next      = val_reg;
        acc_next      = acc_reg;
        rsp_next      = '0;
        ram_we        = 1'b0;
        ram_waddr     = AW'(k_reg_m1);
        ram_wdata     = val_reg;
        ram_re        = 1'b0;
        ram_raddr     = AW'(k_first_m1);
        case (state_reg)
            ST_CLEAR:
            begin
                ram_we        = 1'b1;
                ram_waddr     = clr_addr_reg;
                ram_wdata     = '0;
                clr_addr_next = clr_addr_reg + AW'(1);
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (trivial)
                    begin
                        rsp_next.done     = 1'b1;
                        rsp_next.rejected = (req.opcode == OP_UPDATE);
                    end
                    else
                    begin
                        ram_re   = 1'b1;
                        k_next   = k_first;
                        op_next  = req.opcode;
                        val_next = req.value;
                        acc_next = '0;
                    end
                end
            end
            ST_WALK:
            begin
                // ram_rdata holds node k_reg here.
                if (op_reg == OP_UPDATE)
                begin
                    ram_we    = (ram_rdata < val_reg);
                    ram_raddr = AW'(k_up_m1);
                    k_next    = k_up;
                end
                else
                begin
                    ram_raddr = AW'(k_down_m1);
                    k_next    = k_down;
                    acc_next  = node_max;
                end
                ram_re = walk_more;
                if (!walk_more)
                begin
                    rsp_next.done       = 1'b1;
                    rsp_next.prefix_max = (op_reg == OP_QUERY) ? node_max : '0;
                end
            end
            default:
            begin
                clr_addr_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            rsp_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            rsp_reg      <= rsp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg   <= k_next;
        op_reg  <= op_next;
        val_reg <= val_next;
        acc_reg <= acc_next;
    end

    assign busy = (state_reg != ST_IDLE);
    assign rsp  = rsp_reg;

endmodule

`default_nettype wire

// ----- rtl/fpmt_checker.sv -----
// Port-level checks for the Fenwick prefix-maximum tree unit, bound to its top level.
// Depends on fpmt_pkg and fenwick_prefix_max_tree_unit.
`default_nettype none

module fpmt_checker (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic                       busy,
    input  wire logic                       done,
    input  wire logic [fpmt_pkg::VAL_W-1:0] prefix_max,
    input  wire logic                       rejected
);

    import fpmt_pkg::*;

    // A result only closes a request: the unit was walking or just took one.
    a_done_has_request: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy || start))
        else $error("result without a request");

    // The unit is free again in the cycle it shows a result.
    a_done_frees: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("busy while showing a result");

    // A rejected update carries no maximum.
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rejected) |-> (prefix_max == '0))
        else $error("rejected result with nonzero prefix_max");

    // An accepted request either answers at once or keeps the unit busy.
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (done || busy))
        else $error("accepted request dropped");

endmodule

bind fenwick_prefix_max_tree_unit fpmt_checker u_fpmt_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .done       (done),
    .prefix_max (prefix_max),
    .rejected   (rejected)
);

`default_nettype wire

// ----- sim/tb_top.sv -----
// Self-checking testbench for fenwick_prefix_max_tree_unit: table-driven and random
// requests checked against a behavioral prefix-maximum tree, with APB size changes.
// Depends on rtl/fpmt_pkg.sv and the unit's RTL.
`timescale 1ns / 1ps

module tb_top;

    import fpmt_pkg::*;

    localparam int TREE_SIZE = 1024;
    localparam int ITEMS_PER_PHASE = 160;
    localparam int N_PHASES = 11;
    localparam int N_DIRECTED = 23;
    localparam int SETTLE_CYCLES = 20;

    // Word index that maps to no register; writes there must be dropped.
    localparam logic REG_UNMAPPED = ~REG_USED_SIZE;

    typedef struct {
        logic [VAL_W-1:0] prefix_max;
        logic             rejected;
    } answer_t;

    // One row of the directed table. When typed is set the expected answer is the
    // one written in the row; otherwise it comes from the behavioral tree.
    typedef struct {
        logic             op;
        logic [IDX_W-1:0] idx;
        logic [VAL_W-1:0] val;
        bit               typed;
        logic [VAL_W-1:0] want_max;
        logic             want_rej;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic opcode = OP_UPDATE;
    logic [IDX_W-1:0] index = '0;
    logic [VAL_W-1:0] value = '0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;

    logic busy;
    logic done;
    logic [VAL_W-1:0] prefix_max;
    logic rejected;
    logic [PDATA_W-1:0] prdata;
    logic pready;

    // Behavioral copy of the tree and of the size register.
    logic [VAL_W-1:0] tree_nodes_model [0:TREE_SIZE];
    logic [CFG_W-1:0] cfg_used_size = USED_SIZE_RESET;

    answer_t expected_answers[$];
    int mismatch_count = 0;
    bit no_idle = 1'b0;
    int random_count = 0;

    fenwick_prefix_max_tree_unit #(
        .SIZE(TREE_SIZE)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .opcode(opcode),
        .index(index),
        .value(value),
        .done(done),
        .prefix_max(prefix_max),
        .rejected(rejected),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always #2 clk = ~clk;

    // The directed table runs with the reset size of 1024 and a cleared tree.
    // Rows with typed answers are the ones obvious by inspection: empty prefixes,
    // rejected updates, a small value at entry 0, and the maximum value stored at the very
    // last entry, which only the top node (covering all 1024 entries) sees.
    stim_row_t directed_rows [N_DIRECTED] = '{
        '{OP_QUERY,  11'd0,    31'd0,          1'b1, 31'd0,          1'b0},
        '{OP_QUERY,  11'd1023, 31'd0,          1'b1, 31'd0,          1'b0},
        '{OP_QUERY,  11'h7FF,  31'h7FFF_FFFF,  1'b1, 31'd0,          1'b0},
        '{OP_QUERY,  11'h400,  31'd17,         1'b1, 31'd0,          1'b0},
        '{OP_UPDATE, 11'h7FF,  31'h7FFF_FFFF,  1'b1, 31'd0,          1'b1},
        '{OP_UPDATE, 11'h400,  31'd3,          1'b1, 31'd0,          1'b1},
        '{OP_UPDATE, 11'd1023, 31'h7FFF_FFFF,  1'b1, 31'd0,          1'b0},
        '{OP_QUERY,  11'd1022, 31'd0,          1'b1, 31'd0,          1'b0},
        '{OP_QUERY,  11'd1023, 31'd0,          1'b1, 31'h7FFF_FFFF,  1'b0},
        '{OP_UPDATE, 11'd0,    31'd0,          1'b1, 31'd0,          1'b0},
        '{OP_UPDATE, 11'd0,    31'd5,          1'b1, 31'd0,          1'b0},
        '{OP_QUERY,  11'd0,    31'd0,          1'b1, 31'd5,          1'b0},
        '{OP_UPDATE, 11'd512,  31'd100,        1'b0, 31'd0,          1'b0},
        '{OP_UPDATE, 11'd511,  31'd50,         1'b0, 31'd0,          1'b0},
        '{OP_UPDATE, 11'd3,    31'd9,          1'b0, 31'd0,          1'b0},
        '{OP_QUERY,  11'd2,    31'd0,          1'b0, 31'd0,          1'b0},
        '{OP_QUERY,  11'd3,    31'd0,          1'b0, 31'd0,          1'b0},
        '{OP_QUERY,  11'd511,  31'd0,          1'b0, 31'd0,          1'b0},
        '{OP_QUERY,  11'd512,  31'd0,          1'b0, 31'd0,          1'b0},
        '{OP_UPDATE, 11'd3,    31'd4,          1'b0, 31'd0,          1'b0},
        '{OP_QUERY,  11'd1000, 31'd0,          1'b0, 31'd0,          1'b0},
        '{OP_UPDATE, 11'd1022, 31'h2AAA_AAAA,  1'b0, 31'd0,          1'b0},
        '{OP_QUERY,  11'd1022, 31'h5555_5555,  1'b0, 31'd0,          1'b0}
    };

    // Size register settings for the random phases. They cover the smallest and
    // largest legal sizes, zero (nothing in use), and values past the tree size,
    // which must behave like the full tree.
    logic [CFG_W-1:0] phase_sizes [N_PHASES] = '{
        11'd2047, 11'd1, 11'd0, 11'd7, 11'd1025, 11'd100,
        11'd512, 11'd1023, 11'd1024, 11'd33, 11'd300
    };

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t ns: mismatch on %s: got 0x%0h, expected 0x%0h",
                 $time, what, got, want);
        mismatch_count++;
    endtask

    // Behavioral tree step: applies one request to the model state and returns the
    // answer the unit should give for it.
    function automatic void fenwick_apply(input logic op, input logic [IDX_W-1:0] idx,
                                          input logic [VAL_W-1:0] val,
                                          output logic [VAL_W-1:0] best,
                                          output logic refused);
        int n;
        int pos;
        int k;
        n = (int'(cfg_used_size) > TREE_SIZE) ? TREE_SIZE : int'(cfg_used_size);
        pos = $signed(idx);
        best = '0;
        refused = 1'b0;
        if (op == OP_UPDATE) begin
            if (pos < 0 || pos >= n) begin
                refused = 1'b1;
            end
            else begin
                // Walk upward: every node whose range holds the entry keeps the larger value.
                for (k = pos + 1; k <= n; k += k & (-k)) begin
                    if (tree_nodes_model[k] < val)
                        tree_nodes_model[k] = val;
                end
            end
        end
        else if (pos >= 0 && n > 0) begin
            // Walk downward from the clamped end of the prefix.
            k = (pos >= n) ? n : pos + 1;
            while (k > 0) begin
                if (tree_nodes_model[k] > best)
                    best = tree_nodes_model[k];
                k -= k & (-k);
            end
        end
    endfunction

    // Presents one request and returns at the edge where it is taken. The start line
    // is only touched once per time step: either lowered for an idle gap, or raised
    // together with the new fields.
    task automatic issue_request(input logic op, input logic [IDX_W-1:0] idx,
                                 input logic [VAL_W-1:0] val, input bit typed,
                                 input logic [VAL_W-1:0] want_max, input logic want_rej);
        int gap;
        answer_t answer;
        gap = 0;
        if (!no_idle && $urandom_range(99) < 36)
            gap = $urandom_range(12, 1);
        if (gap > 0) begin
            // Junk on the fields while start is low must be ignored.
            start <= 1'b0;
            opcode <= 1'($urandom_range(1));
            index <= IDX_W'($urandom);
            value <= VAL_W'($urandom);
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        opcode <= op;
        index <= idx;
        value <= val;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        fenwick_apply(op, idx, val, answer.prefix_max, answer.rejected);
        if (typed) begin
            answer.prefix_max = want_max;
            answer.rejected = want_rej;
        end
        expected_answers.push_back(answer);
    endtask

    // Drops start and holds off until every outstanding request has answered.
    // Always waits for a clock edge before checking, so start is not assigned twice in one step.
    task automatic wait_all_answered();
        start <= 1'b0;
        do
            @(posedge clk);
        while (expected_answers.size() != 0);
    endtask

    // APB write (setup then access) followed by a read of the size register.
    // The upper data bits are random; only the low 11 bits belong to the register.
    task automatic write_register(input logic reg_idx, input logic [CFG_W-1:0] size_value);
        logic [PDATA_W-1:0] wdata;
        wdata = $urandom;
        wdata[CFG_W-1:0] = size_value;
        wait_all_answered();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {reg_idx, 2'b00};
        pwdata <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        // The write lands at this edge.
        if (reg_idx == REG_USED_SIZE)
            cfg_used_size = wdata[CFG_W-1:0];
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b0;
        paddr <= {REG_USED_SIZE, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== {{(PDATA_W-CFG_W){1'b0}}, cfg_used_size})
            report_mismatch("used_size readback", prdata, 32'(cfg_used_size));
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // Random index: mostly inside the size in use, with a share of -1, of indexes past
    // the size (rejected updates, clamped queries) and of anything the field can hold.
    function automatic logic [IDX_W-1:0] pick_index(input int n);
        int r;
        r = $urandom_range(99);
        if (n > 0 && r < 70)
            return IDX_W'($urandom_range(n - 1));
        if (r < 80)
            return '1;
        if (r < 90 && n < TREE_SIZE)
            return IDX_W'($urandom_range(TREE_SIZE - 1, n));
        return IDX_W'($urandom);
    endfunction

    // Values grow with the run so prefix maxima keep changing instead of saturating
    // early; a few full-range values still go in.
    function automatic logic [VAL_W-1:0] pick_value(input int count);
        longint ceiling;
        ceiling = longint'(count + 1) * 1_200_000;
        if (ceiling > 64'h7FFF_FFFF || $urandom_range(99) < 3)
            ceiling = 64'h7FFF_FFFF;
        return VAL_W'($urandom_range(32'(ceiling)));
    endfunction

    // Result side: the unit shows each answer for exactly one cycle, so every done
    // is taken at the edge that ends it and matched against the oldest expectation.
    always @(posedge clk) begin : result_check
        answer_t want;
        if (rst_n && done) begin
            if (expected_answers.size() == 0) begin
                report_mismatch("unexpected result", 32'(prefix_max), 32'd0);
            end
            else begin
                want = expected_answers.pop_front();
                if (prefix_max !== want.prefix_max)
                    report_mismatch("prefix_max", 32'(prefix_max), 32'(want.prefix_max));
                if (rejected !== want.rejected)
                    report_mismatch("rejected", 32'(rejected), 32'(want.rejected));
            end
        end
    end

    initial begin : stimulus
        int p;
        int i;
        int n;
        int w;
        logic op;

        for (i = 0; i <= TREE_SIZE; i++)
            tree_nodes_model[i] = '0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed table. The first request also waits out the clearing pass, since
        // busy stays high until every node has been zeroed.
        for (i = 0; i < N_DIRECTED; i++)
            issue_request(directed_rows[i].op, directed_rows[i].idx, directed_rows[i].val,
                          directed_rows[i].typed, directed_rows[i].want_max,
                          directed_rows[i].want_rej);

        // A write to the unmapped word must leave the size register alone.
        write_register(REG_UNMAPPED, 11'($urandom));

        for (p = 0; p < N_PHASES; p++) begin
            write_register(REG_USED_SIZE, phase_sizes[p]);
            n = (int'(cfg_used_size) > TREE_SIZE) ? TREE_SIZE : int'(cfg_used_size);
            // One phase runs back to back with no random idle gaps.
            no_idle = (p == 6);
            for (i = 0; i < ITEMS_PER_PHASE; i++) begin
                // Halfway through each phase the sender stops until the pipe is empty.
                if (i == ITEMS_PER_PHASE / 2)
                    wait_all_answered();
                op = $urandom_range(1) ? OP_QUERY : OP_UPDATE;
                issue_request(op, pick_index(n), pick_value(random_count),
                              1'b0, '0, 1'b0);
                random_count++;
            end
        end
        no_idle = 1'b0;

        start <= 1'b0;
        for (w = 0; w < 200 && expected_answers.size() != 0; w++)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (expected_answers.size() != 0)
            report_mismatch("results never returned", 32'd0, 32'(expected_answers.size()));

        if (mismatch_count == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

    // Watchdog: well beyond the slowest legal run (about 1800 requests, each with its
    // tree walk and an idle gap, and the clearing pass).
    initial begin : watchdog
        #2_000_000;
        $display("tb_top NOT OK");
        $finish;
    end

endmodule
